[hdl/itp_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itp_pkg
// Shared types, codes and helpers for the integer text parser.
// ----------------------------------------------------------------------------
package itp_pkg;

	localparam int unsigned MAX_TEXT_LEN_DEF = 4095;
	localparam int unsigned BASE_W           = 6;
	localparam int unsigned CNT_W            = 12;
	localparam int unsigned CNT_MAX          = 4095;
	localparam int unsigned MAX_BASE         = 36;
	localparam logic [BASE_W-1:0] BASE_RST   = 6'd10;

	typedef enum logic [0:0] {
		REG_NUMBER_BASE = 1'b0,
		REG_SIGNED_MODE = 1'b1
	} itp_reg_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_NO_DIGIT = 2'd1,
		ST_RANGE    = 2'd2,
		ST_BAD_BASE = 2'd3
	} itp_status_t;

	typedef enum logic [2:0] {
		PH_SPACE  = 3'd0,
		PH_START  = 3'd1,
		PH_ZERO   = 3'd2,
		PH_HEX    = 3'd3,
		PH_DIGITS = 3'd4,
		PH_DONE   = 3'd5
	} itp_phase_t;

	// finished text, handed from the parse stage to the result stage
	typedef struct packed {
		logic [63:0]      acc;
		logic             ovf;
		logic             neg;
		logic             bad_base;
		logic             seen;
		logic [CNT_W-1:0] count;
		logic             smode;
	} itp_fin_t;

	localparam logic [7:0] DIGIT_NONE = 8'hff;

	function automatic logic [7:0] digit_of(input logic [7:0] c);
		logic [7:0] d;
		d = DIGIT_NONE;
		if (c >= 8'd48 && c <= 8'd57) begin
			d = c - 8'd48;
		end else if (c >= 8'd97 && c <= 8'd122) begin
			d = c - 8'd87;
		end else if (c >= 8'd65 && c <= 8'd90) begin
			d = c - 8'd55;
		end
		return d;
	endfunction

	function automatic logic base_bad(input logic [BASE_W-1:0] b);
		return (b == BASE_W'(1)) || (b > BASE_W'(MAX_BASE));
	endfunction

endpackage

[hdl/itp_parse.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itp_parse
// Per-character parse state update and hand-off register for finished texts.
// ----------------------------------------------------------------------------
module itp_parse #(
	parameter int unsigned MAX_TEXT_LEN = itp_pkg::MAX_TEXT_LEN_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [7:0]                    char_code,
	input  logic                          last_char,
	input  logic [itp_pkg::BASE_W-1:0]    number_base,
	input  logic                          signed_mode,
	input  logic                          take_fin,
	output itp_pkg::itp_fin_t             fin_s1,
	output logic                          fin_v_s1
);
	import itp_pkg::*;

	localparam int unsigned IDX_W = $clog2(MAX_TEXT_LEN + 2);
	localparam int unsigned CMP_W = (IDX_W > CNT_W) ? IDX_W : CNT_W;

	itp_phase_t        phase_q, phase0, nphase;
	logic [63:0]       acc_q, nacc;
	logic              ovf_q, novf;
	logic              neg_q, nneg;
	logic [BASE_W-1:0] base_q, base0, tbase;
	logic              seen_q, nseen;
	logic [IDX_W-1:0]  idx_q, nidx;
	logic [IDX_W-1:0]  end_q, nend, end_here;
	logic              first, take;
	logic [7:0]        dig;
	logic [69:0]       prod;
	logic              accept, acc_last;
	logic [CNT_W-1:0]  cnt_sat;

	assign accept   = in_valid && !in_stall;
	assign acc_last = accept && last_char;
	assign in_stall = fin_v_s1 && !take_fin;
	assign end_here = IDX_W'(idx_q + 1'b1);
	assign dig      = digit_of(char_code);
	assign prod     = 70'(acc_q) * 70'(tbase) + 70'(dig);

	always_comb begin
		first  = (idx_q == '0) && (phase_q == PH_SPACE);
		base0  = first ? number_base : base_q;
		phase0 = (first && base_bad(number_base)) ? PH_DONE : phase_q;
		nphase = phase0;
		nacc   = acc_q;
		novf   = ovf_q;
		nneg   = neg_q;
		nseen  = seen_q;
		nend   = end_q;
		tbase  = base0;
		take   = 1'b0;
		case (phase0)
			PH_SPACE, PH_START: begin
				if (phase0 == PH_SPACE &&
				    ((char_code >= 8'd9 && char_code <= 8'd13) || char_code == 8'd32)) begin
					nphase = PH_SPACE;
				end else if (phase0 == PH_SPACE &&
				             (char_code == 8'd43 || char_code == 8'd45)) begin
					nneg   = (char_code == 8'd45);
					nphase = PH_START;
				end else if ((base0 == '0 || base0 == BASE_W'(16)) && char_code == 8'd48) begin
					nend   = end_here;
					nphase = PH_ZERO;
				end else begin
					if (base0 == '0) begin
						tbase = BASE_W'(10);
					end
					take = 1'b1;
				end
			end
			PH_ZERO: begin
				if (char_code == 8'd120 || char_code == 8'd88) begin
					tbase  = BASE_W'(16);
					nphase = PH_HEX;
				end else begin
					if (base0 == '0) begin
						tbase = BASE_W'(8);
					end
					nseen = 1'b1;
					take  = 1'b1;
				end
			end
			PH_HEX, PH_DIGITS: begin
				take = 1'b1;
			end
			default: begin
				nphase = phase0;
			end
		endcase
		if (take) begin
			if (tbase < BASE_W'(2) || dig >= 8'(tbase)) begin
				nphase = PH_DONE;
			end else begin
				nseen = 1'b1;
				if (ovf_q || prod[69:64] != '0) begin
					novf = 1'b1;
					nacc = '1;
				end else begin
					nacc = prod[63:0];
				end
				nend   = end_here;
				nphase = PH_DIGITS;
			end
		end
		nidx = (idx_q < IDX_W'(MAX_TEXT_LEN)) ? IDX_W'(idx_q + 1'b1) : idx_q;
		cnt_sat = (CMP_W'(nend) > CMP_W'(CNT_MAX)) ? CNT_W'(CNT_MAX) : CNT_W'(nend);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_SPACE;
			acc_q   <= '0;
			ovf_q   <= 1'b0;
			neg_q   <= 1'b0;
			base_q  <= '0;
			seen_q  <= 1'b0;
			idx_q   <= '0;
			end_q   <= '0;
		end else if (acc_last) begin
			phase_q <= PH_SPACE;
			acc_q   <= '0;
			ovf_q   <= 1'b0;
			neg_q   <= 1'b0;
			base_q  <= '0;
			seen_q  <= 1'b0;
			idx_q   <= '0;
			end_q   <= '0;
		end else if (accept) begin
			phase_q <= nphase;
			acc_q   <= nacc;
			ovf_q   <= novf;
			neg_q   <= nneg;
			base_q  <= tbase;
			seen_q  <= nseen;
			idx_q   <= nidx;
			end_q   <= nend;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fin_v_s1 <= 1'b0;
		end else if (acc_last) begin
			fin_v_s1 <= 1'b1;
		end else if (take_fin) begin
			fin_v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (acc_last) begin
			fin_s1.acc      <= nacc;
			fin_s1.ovf      <= novf;
			fin_s1.neg      <= nneg;
			fin_s1.bad_base <= base_bad(tbase);
			fin_s1.seen     <= nseen || (nphase == PH_ZERO);
			fin_s1.count    <= cnt_sat;
			fin_s1.smode    <= signed_mode;
		end
	end

endmodule

[hdl/itp_result.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itp_result
// Sign, clamp and status of a finished text, held in the output register.
// ----------------------------------------------------------------------------
module itp_result (
	input  logic                          clk,
	input  logic                          arst_n,
	input  itp_pkg::itp_fin_t             fin_s1,
	input  logic                          fin_v_s1,
	output logic                          take_fin,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [63:0]                   parsed_value,
	output logic [1:0]                    status,
	output logic [itp_pkg::CNT_W-1:0]     consumed_count
);
	import itp_pkg::*;

	localparam logic [63:0] LIM = 64'h8000_0000_0000_0000;

	logic [63:0]      val, negv;
	itp_status_t      st;
	logic [CNT_W-1:0] cnt;

	assign take_fin = !out_valid || !out_stall;
	assign negv     = 64'd0 - fin_s1.acc;

	always_comb begin
		val = '0;
		st  = ST_OK;
		cnt = fin_s1.count;
		if (fin_s1.bad_base) begin
			st  = ST_BAD_BASE;
			cnt = '0;
		end else if (!fin_s1.seen) begin
			st  = ST_NO_DIGIT;
			cnt = '0;
		end else if (!fin_s1.smode) begin
			if (fin_s1.ovf) begin
				val = '1;
				st  = ST_RANGE;
			end else begin
				val = fin_s1.neg ? negv : fin_s1.acc;
			end
		end else if (fin_s1.ovf) begin
			val = fin_s1.neg ? LIM : ~LIM;
			st  = ST_RANGE;
		end else if (fin_s1.neg) begin
			if (fin_s1.acc[63] && fin_s1.acc[62:0] != '0) begin
				val = LIM;
				st  = ST_RANGE;
			end else begin
				val = negv;
			end
		end else if (fin_s1.acc[63]) begin
			val = ~LIM;
			st  = ST_RANGE;
		end else begin
			val = fin_s1.acc;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (take_fin) begin
			out_valid <= fin_v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (take_fin && fin_v_s1) begin
			parsed_value   <= val;
			status         <= st;
			consumed_count <= cnt;
		end
	end

endmodule

[hdl/integer_text_parser_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// integer_text_parser_top
// Text-to-integer parser, one character per request.
// ----------------------------------------------------------------------------
// Input channel (in_valid / in_stall) carries one character per request with
// last_char marking the end of a text. Output channel (out_valid / out_stall)
// carries one result per text: parsed_value, status, consumed_count.
// A character is taken every cycle while in_stall is low; the running value
// is updated by one 64 x 6 multiply-add per character. A result passes
// through the parse hand-off register, then the output register, after the
// last character is taken. While out_stall holds a result, one more finished
// text can wait in the hand-off register; in_stall rises only when both are
// full. number_base (index 0) is sampled on the first character of a text,
// signed_mode (index 1) when the last character is taken; write them only
// while the block is idle.
// Reset clears parse state and both valid flags, and sets number_base to 10
// and signed_mode to 1.
// ----------------------------------------------------------------------------
module integer_text_parser_top #(
	parameter int unsigned MAX_TEXT_LEN = itp_pkg::MAX_TEXT_LEN_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic                          cfg_index,
	input  logic [itp_pkg::BASE_W-1:0]    cfg_data,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [7:0]                    char_code,
	input  logic                          last_char,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [63:0]                   parsed_value,
	output logic [1:0]                    status,
	output logic [itp_pkg::CNT_W-1:0]     consumed_count
);
	import itp_pkg::*;

	logic [BASE_W-1:0] base_q;
	logic              smode_q;
	itp_fin_t          fin_s1;
	logic              fin_v_s1;
	logic              take_fin;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q  <= BASE_RST;
			smode_q <= 1'b1;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_NUMBER_BASE: base_q  <= cfg_data;
				REG_SIGNED_MODE: smode_q <= cfg_data[0];
				default:         base_q  <= base_q;
			endcase
		end
	end

	itp_parse #(
		.MAX_TEXT_LEN(MAX_TEXT_LEN)
	) u_parse (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.char_code   (char_code),
		.last_char   (last_char),
		.number_base (base_q),
		.signed_mode (smode_q),
		.take_fin    (take_fin),
		.fin_s1      (fin_s1),
		.fin_v_s1    (fin_v_s1)
	);

	itp_result u_result (
		.clk            (clk),
		.arst_n         (arst_n),
		.fin_s1         (fin_s1),
		.fin_v_s1       (fin_v_s1),
		.take_fin       (take_fin),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.parsed_value   (parsed_value),
		.status         (status),
		.consumed_count (consumed_count)
	);

endmodule

[hdl/itp_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itp_checker
// Port-level checks for the integer text parser, bound to the top level.
// ----------------------------------------------------------------------------
module itp_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          in_valid,
	input logic                          in_stall,
	input logic                          last_char,
	input logic                          out_valid,
	input logic                          out_stall,
	input logic [63:0]                   parsed_value,
	input logic [1:0]                    status,
	input logic [itp_pkg::CNT_W-1:0]     consumed_count
);
	import itp_pkg::*;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(parsed_value) &&
		$stable(status) && $stable(consumed_count))
		else $error("result changed while stalled");

	a_out_cause: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !$past(out_valid) |-> $past(in_valid && !in_stall && last_char, 2))
		else $error("result without a last character two cycles before");

	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == ST_NO_DIGIT || status == ST_BAD_BASE) |->
		parsed_value == 64'd0 && consumed_count == '0)
		else $error("no-digit or bad-base result not zero");

	a_range_val: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ST_RANGE |->
		parsed_value == 64'hffff_ffff_ffff_ffff ||
		parsed_value == 64'h8000_0000_0000_0000 ||
		parsed_value == 64'h7fff_ffff_ffff_ffff)
		else $error("range error with unclamped value");

endmodule

bind integer_text_parser_top itp_checker u_itp_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.in_valid       (in_valid),
	.in_stall       (in_stall),
	.last_char      (last_char),
	.out_valid      (out_valid),
	.out_stall      (out_stall),
	.parsed_value   (parsed_value),
	.status         (status),
	.consumed_count (consumed_count)
);

[verif/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for integer_text_parser_top.
// ----------------------------------------------------------------------------
// Characters are sent one request at a time, with random gaps. A tracker
// object parses the same stream and queues the value, status and count that
// each last-marked character should produce. Results are compared in order.
// Short directed texts run first, at the reset register values. Then come
// register settings from auto-detect through the bad radixes, with random
// texts: digit runs, boundary values near 2^63 and 2^64, bare prefixes and
// signs, and byte noise. The result side stalls at random and holds off for
// long stretches twice, so the block fills up and stalls its input.
// ----------------------------------------------------------------------------
module tb_top;
	import itp_pkg::*;

	localparam logic [63:0] SIGN_BIT = 64'h8000_0000_0000_0000;

	typedef struct {
		logic [63:0]      value;
		itp_status_t      st;
		logic [CNT_W-1:0] count;
	} parse_result_t;

	class parsed_int_tracker;
		logic [BASE_W-1:0] radix_reg;
		bit                clamp_reg;
		itp_phase_t        phase;
		bit [63:0]         acc;
		bit                ovf;
		bit                neg;
		bit                seen;
		int unsigned       act_base;
		int unsigned       idx;
		int unsigned       num_end;
		parse_result_t     awaited[$];
		int unsigned       errors;

		function new();
			radix_reg = BASE_RST;
			clamp_reg = 1'b1;
			errors = 0;
			clear_text();
		endfunction

		function void clear_text();
			phase = PH_SPACE;
			acc = '0;
			ovf = 1'b0;
			neg = 1'b0;
			seen = 1'b0;
			act_base = 0;
			idx = 0;
			num_end = 0;
		endfunction

		function bit radix_invalid(int unsigned b);
			return b == 1 || b > MAX_BASE;
		endfunction

		function int unsigned char_digit(byte unsigned c);
			if (c >= "0" && c <= "9") return c - "0";
			if (c >= "a" && c <= "z") return c - "a" + 10;
			if (c >= "A" && c <= "Z") return c - "A" + 10;
			return 255;
		endfunction

		function void add_digit(byte unsigned c);
			int unsigned d;
			d = char_digit(c);
			if (act_base < 2 || d >= act_base) begin
				phase = PH_DONE;
				return;
			end
			seen = 1'b1;
			if (ovf || acc > ({64{1'b1}} - 64'(d)) / 64'(act_base)) begin
				ovf = 1'b1;
				acc = {64{1'b1}};
			end else begin
				acc = acc * 64'(act_base) + 64'(d);
			end
			num_end = idx + 1;
			phase = PH_DIGITS;
		endfunction

		function void begin_number(byte unsigned c);
			if ((act_base == 0 || act_base == 16) && c == "0") begin
				num_end = idx + 1;
				phase = PH_ZERO;
				return;
			end
			if (act_base == 0) act_base = 10;
			add_digit(c);
		endfunction

		// one accepted character; a last-marked one queues its result
		function void take_char(byte unsigned c, bit last);
			parse_result_t r;
			if (idx == 0 && phase == PH_SPACE) begin
				act_base = radix_reg;
				if (radix_invalid(act_base)) phase = PH_DONE;
			end
			case (phase)
				PH_SPACE: begin
					if ((c >= 8'd9 && c <= 8'd13) || c == " ") begin
					end else if (c == "+" || c == "-") begin
						neg = (c == "-");
						phase = PH_START;
					end else begin
						begin_number(c);
					end
				end
				PH_START: begin_number(c);
				PH_ZERO: begin
					if (c == "x" || c == "X") begin
						act_base = 16;
						phase = PH_HEX;
					end else begin
						if (act_base == 0) act_base = 8;
						seen = 1'b1;
						add_digit(c);
					end
				end
				PH_HEX, PH_DIGITS: add_digit(c);
				default: begin
				end
			endcase
			if (idx < MAX_TEXT_LEN_DEF) idx++;
			if (!last) return;

			if (phase == PH_ZERO) seen = 1'b1;
			r.value = '0;
			r.st = ST_OK;
			r.count = (num_end > CNT_MAX) ? CNT_W'(CNT_MAX) : CNT_W'(num_end);
			if (radix_invalid(act_base)) begin
				r.st = ST_BAD_BASE;
				r.count = '0;
			end else if (!seen) begin
				r.st = ST_NO_DIGIT;
				r.count = '0;
			end else if (!clamp_reg) begin
				if (ovf) begin
					r.value = {64{1'b1}};
					r.st = ST_RANGE;
				end else begin
					r.value = neg ? -acc : acc;
				end
			end else if (ovf) begin
				r.value = neg ? SIGN_BIT : SIGN_BIT - 1;
				r.st = ST_RANGE;
			end else if (neg) begin
				if (acc > SIGN_BIT) begin
					r.value = SIGN_BIT;
					r.st = ST_RANGE;
				end else begin
					r.value = -acc;
				end
			end else if (acc > SIGN_BIT - 1) begin
				r.value = SIGN_BIT - 1;
				r.st = ST_RANGE;
			end else begin
				r.value = acc;
			end
			awaited.push_back(r);
			clear_text();
		endfunction

		function void check_result(logic [63:0] v, logic [1:0] s, logic [CNT_W-1:0] n);
			parse_result_t want;
			if (awaited.size() == 0) begin
				$error("result with no text pending: parsed_value %h", v);
				errors++;
				return;
			end
			want = awaited.pop_front();
			if (v !== want.value) begin
				$error("parsed_value: expected %h, got %h", want.value, v);
				errors++;
			end
			if (s !== want.st) begin
				$error("status: expected %0d, got %0d", want.st, s);
				errors++;
			end
			if (n !== want.count) begin
				$error("consumed_count: expected %0d, got %0d", want.count, n);
				errors++;
			end
		endfunction
	endclass

	logic              clk;
	logic              arst_n;
	logic              cfg_we;
	logic              cfg_index;
	logic [BASE_W-1:0] cfg_data;
	logic              in_valid;
	logic              in_stall;
	logic [7:0]        char_code;
	logic              last_char;
	logic              out_valid;
	logic              out_stall;
	logic [63:0]       parsed_value;
	logic [1:0]        status;
	logic [CNT_W-1:0]  consumed_count;

	parsed_int_tracker tracker = new();
	int unsigned       hold_asks = 0;
	int unsigned       ext_sel = 0;
	bit                calm_tx = 1'b0;

	integer_text_parser_top u_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.char_code      (char_code),
		.last_char      (last_char),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.parsed_value   (parsed_value),
		.status         (status),
		.consumed_count (consumed_count)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		#4_000_000;
		$display("tb_top failed");
		$finish;
	end

	// mostly no gap, some short, a few long
	function automatic int unsigned idle_len(bit calm);
		int unsigned r;
		r = $urandom_range(0, 99);
		if (calm || r < 65) return 0;
		if (r < 93) return $urandom_range(1, 3);
		return $urandom_range(6, 40);
	endfunction

	function automatic byte unsigned digit_char(int unsigned d);
		if (d < 10) return 8'(d) + "0";
		return 8'(d - 10) + ($urandom_range(0, 1) ? "a" : "A");
	endfunction

	function automatic void push_value(ref byte unsigned t[$], input bit [63:0] v,
			input int unsigned radix);
		byte unsigned digs[$];
		do begin
			digs.push_front(digit_char(int'(v % 64'(radix))));
			v = v / 64'(radix);
		end while (v != 0);
		foreach (digs[i]) t.push_back(digs[i]);
	endfunction

	function automatic void random_text(ref byte unsigned t[$], input int unsigned radix);
		int unsigned kind;
		int unsigned eff;
		int unsigned r;
		bit [63:0]   v;
		eff = (radix < 2 || radix > MAX_BASE) ? 10 : radix;
		kind = $urandom_range(0, 99);
		v = '0;
		if ($urandom_range(0, 9) < 3) begin
			repeat ($urandom_range(1, 3)) begin
				r = $urandom_range(8, 13);
				t.push_back(r == 8 ? " " : 8'(r));
			end
		end
		r = $urandom_range(0, 3);
		if (kind >= 60 && kind < 80) begin
			case (ext_sel % 6)
				0: v = '0;
				1: v = SIGN_BIT - 1;
				2: v = SIGN_BIT;
				3: v = SIGN_BIT + 1;
				4: v = {64{1'b1}};
				default: v = {$urandom, $urandom};
			endcase
			if ((ext_sel / 6) % 2 == 1) r = 1;
			ext_sel++;
		end
		if (r == 0) t.push_back("+");
		else if (r == 1) t.push_back("-");
		if (radix == 0 || radix == 16) begin
			r = $urandom_range(0, 5);
			if (r < 2) begin
				t.push_back("0");
				t.push_back(r == 0 ? "x" : "X");
				eff = 16;
			end else if (r == 2 && radix == 0) begin
				t.push_back("0");
				eff = 8;
			end
		end
		if (kind < 60) begin
			r = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 24) : $urandom_range(1, 6);
			repeat (r) t.push_back(digit_char($urandom_range(0, eff - 1)));
		end else if (kind < 80) begin
			push_value(t, v, eff);
			if ($urandom_range(0, 3) == 0) t.push_back(digit_char($urandom_range(0, eff - 1)));
		end else if (kind < 88) begin
			// 0x prefix followed by nothing, a g or a dot
			t.push_back("0");
			t.push_back("x");
			if ($urandom_range(0, 1)) t.push_back($urandom_range(0, 1) ? "g" : ".");
		end else begin
			repeat ($urandom_range(1, 6)) t.push_back(8'($urandom_range(0, 255)));
		end
		if ($urandom_range(0, 9) < 3)
			repeat ($urandom_range(1, 3)) t.push_back(8'($urandom_range(0, 255)));
		if (t.size() == 0) t.push_back(8'($urandom_range(0, 255)));
	endfunction

	task automatic send_char(byte unsigned c, bit last, int unsigned gap);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		char_code <= c;
		last_char <= last;
		do @(posedge clk); while (in_stall);
		tracker.take_char(c, last);
	endtask

	task automatic send_text(ref byte unsigned t[$]);
		if ($urandom_range(0, 7) == 0) calm_tx = ~calm_tx;
		foreach (t[i]) send_char(t[i], i == t.size() - 1, idle_len(calm_tx));
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (tracker.awaited.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_regs(logic [BASE_W-1:0] radix, bit clamp);
		cfg_we <= 1'b1;
		cfg_index <= REG_NUMBER_BASE;
		cfg_data <= radix;
		@(posedge clk);
		cfg_index <= REG_SIGNED_MODE;
		cfg_data <= {{(BASE_W-1){1'b0}}, clamp};
		@(posedge clk);
		cfg_we <= 1'b0;
		tracker.radix_reg = radix;
		tracker.clamp_reg = clamp;
	endtask

	initial begin : stimulus
		byte unsigned      text[$];
		string             samples[5];
		int unsigned       plan_base[9];
		bit                plan_clamp[9];
		logic [BASE_W-1:0] radix;
		bit                clamp;
		int unsigned       n;
		samples = '{"\t-12a", "+0", "42", "-", "z"};
		plan_base = '{0, 16, 36, 2, 1, 63, 8, 0, 10};
		plan_clamp = '{1, 0, 1, 0, 1, 0, 0, 1, 1};
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= REG_NUMBER_BASE;
		cfg_data <= '0;
		in_valid <= 1'b0;
		char_code <= '0;
		last_char <= 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset registers: radix 10, signed
		foreach (samples[k]) begin
			text.delete();
			for (int j = 0; j < samples[k].len(); j++) text.push_back(samples[k][j]);
			send_text(text);
		end
		text = '{8'hff};
		send_text(text);
		text = '{8'h00};
		send_text(text);

		for (int p = 0; p < 10; p++) begin
			drain();
			if (p == 9) begin
				radix = BASE_W'($urandom_range(0, 63));
				clamp = 1'($urandom_range(0, 1));
			end else begin
				radix = BASE_W'(plan_base[p]);
				clamp = plan_clamp[p];
			end
			write_regs(radix, clamp);
			if (p == 1 || p == 6) hold_asks <= hold_asks + 1;
			n = (radix == 1 || radix > MAX_BASE) ? 4 : 8;
			for (int k = 0; k < n; k++) begin
				text.delete();
				random_text(text, radix);
				send_text(text);
			end
		end
		drain();

		if (tracker.errors == 0) begin
			$display("tb_top passed");
		end else begin
			$display("tb_top failed");
		end
		$finish;
	end

	initial begin : result_side
		int unsigned stall_left;
		int unsigned holds_served;
		bit          calm_rx;
		stall_left = 0;
		holds_served = 0;
		calm_rx = 1'b0;
		out_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (out_valid === 1'b1 && !out_stall)
				tracker.check_result(parsed_value, status, consumed_count);
			if (holds_served != hold_asks) begin
				holds_served++;
				stall_left = 150;
			end
			if (stall_left != 0) begin
				out_stall <= 1'b1;
				stall_left--;
			end else begin
				out_stall <= 1'b0;
				if ($urandom_range(0, 63) == 0) calm_rx = ~calm_rx;
				stall_left = idle_len(calm_rx);
			end
		end
	end

endmodule

[integer_text_parser_top.f]
hdl/itp_pkg.sv
hdl/itp_parse.sv
hdl/itp_result.sv
hdl/integer_text_parser_top.sv
hdl/itp_checker.sv
verif/tb_top.sv
